// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers used by the tracker top.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Invariant that must never be broken outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: sv/qirt_pkg.sv
// ---------------------------------------------------------------------------
// QoS1 in-flight tracker package
// Shared types, opcodes, status codes and sizes.
// ---------------------------------------------------------------------------
`default_nettype none

package qirt_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int IN_W      = 72;  // request tdata, byte padded
    localparam int OUT_W     = 72;  // response tdata, byte padded
    localparam int CFG_W     = 32;
    localparam logic [7:0] DUP_BIT = 8'h08;

    // request opcodes
    localparam logic [2:0] OP_RESERVE = 3'd0;
    localparam logic [2:0] OP_ACK     = 3'd1;
    localparam logic [2:0] OP_RETRY   = 3'd2;
    localparam logic [2:0] OP_SEND    = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    // response status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_REJECTED  = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_RETRANSMIT = 3'd4;
    localparam logic [2:0] ST_NONE_DUE  = 3'd5;
    localparam logic [2:0] ST_EXHAUSTED = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_RETRY_MS  = 2'd0;
    localparam logic [1:0] CFG_MAX_SEND  = 2'd1;
    localparam logic [1:0] CFG_MAX_BYTES = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_SEND,
        S_RESP
    } t_state;

    // one slot table entry
    typedef struct packed {
        logic [7:0]  send_cnt;
        logic [31:0] last_send;
        logic [15:0] bytes;
        logic [15:0] id;
    } t_entry;

    // per-request result, minus occupancy and byte total
    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [15:0] id;
        logic [15:0] bytes;
        logic        dup;
    } t_res;

endpackage

`default_nettype wire

// File: sv/qirt_slot_ram.sv
// ---------------------------------------------------------------------------
// Slot table RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module qirt_slot_ram #(
    parameter int SLOTS = qirt_pkg::SLOTS_DEF,
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [IW-1:0]   i_wr_addr,
    input  wire qirt_pkg::t_entry i_wr_data,
    input  wire logic            i_rd_en,
    input  wire logic [IW-1:0]   i_rd_addr,
    output qirt_pkg::t_entry     o_rd_data
);
    import qirt_pkg::*;

    t_entry r_mem [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: sv/qos1_inflight_retry_tracker_top.sv
// ---------------------------------------------------------------------------
// QoS1 in-flight retry tracker
// Slot table of unacknowledged QoS1 publishes with pending byte accounting.
// ---------------------------------------------------------------------------
//
// Channel     Dir  Handshake               Payload
// s_axis      in   tvalid/tready           op, msg_id, msg_bytes, time_ms,
//                                          target_slot, send_ok
// m_axis      out  tvalid/tready           status, chosen_slot, out_id, out_bytes,
//                                          dup_flag, occupied_count, total_bytes
// cfg         in   i_cfg_we (no wait)      index 0 retry ms, 1 max sends, 2 max bytes
//
// Flow: one request at a time. Reserve, ack and retry check walk the slot
// RAM one entry per cycle and stop at the first hit or at the last slot.
// Send result passes S_START, S_SEND and S_RESP; a rejected reserve, a zero-id
// ack, clear and undecoded ops go from S_START straight to S_RESP.
// The single read port sets the walk rate.
// Reset clears the valid bits, occupancy and byte total and loads the register
// defaults; the RAM contents are not cleared (only valid entries are used).
// A new request is taken while a response waits in the output register;
// a further response then holds in S_RESP until m_axis_tready.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module qos1_inflight_retry_tracker_top #(
    parameter int SLOTS = qirt_pkg::SLOTS_DEF,
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int OW = $clog2(SLOTS + 1)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // request: op[2:0], msg_id[18:3], msg_bytes[34:19], time_ms[66:35],
    //          target_slot[70:67], send_ok[71]
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [qirt_pkg::IN_W-1:0]  s_axis_tdata,
    // response: status[2:0], chosen_slot[6:3], out_id[22:7], out_bytes[38:23],
    //           dup_flag[39], occupied_count[44:40], total_bytes[68:45], zero pad
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic [qirt_pkg::OUT_W-1:0]   m_axis_tdata,
    // config write port
    input  wire logic                    i_cfg_we,
    input  wire logic [1:0]              i_cfg_idx,
    input  wire logic [qirt_pkg::CFG_W-1:0] i_cfg_wdata
);
    import qirt_pkg::*;

    t_state r_state, n_state;

    // config
    logic [31:0] r_retry_ms;
    logic [7:0]  r_max_send;
    logic [23:0] r_max_bytes;

    // latched request
    logic [2:0]  r_op;
    logic [15:0] r_id;
    logic [15:0] r_bytes;
    logic [31:0] r_time;
    logic [3:0]  r_tgt;
    logic        r_ok;

    // tracker state
    logic [SLOTS-1:0] r_valid, n_valid;
    logic [OW-1:0]    r_occ, n_occ;
    logic [23:0]      r_pending, n_pending;
    logic [IW-1:0]    r_idx, n_idx;
    t_res             r_res, n_res;

    logic             r_out_valid, n_out_valid;
    logic [OUT_W-1:0] r_out_data, n_out_data;

    // RAM port
    logic        w_we, w_rd_en;
    logic [IW-1:0] w_wr_addr, w_rd_addr;
    t_entry      w_wr_data, w_rd_data;

    logic        w_accept, w_hit, w_last, w_reject, w_tgt_bad;
    logic [24:0] w_sum;
    logic [31:0] w_age;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    // reserve limit check, made before any slot search
    assign w_sum    = {1'b0, r_pending} + {9'b0, r_bytes};
    assign w_reject = (r_id == 16'd0) || (w_sum > {1'b0, r_max_bytes});
    assign w_tgt_bad = (32'(r_tgt) >= SLOTS) || !r_valid[IW'(r_tgt)];

    // per-entry test during the walk; r_idx names the entry in w_rd_data
    assign w_age  = r_time - w_rd_data.last_send;
    assign w_last = (r_idx == IW'(SLOTS - 1));
    always_comb begin
        case (r_op)
            OP_RESERVE: w_hit = !r_valid[r_idx];
            OP_ACK:     w_hit = r_valid[r_idx] && (w_rd_data.id == r_id);
            OP_RETRY:   w_hit = r_valid[r_idx] && (w_age >= r_retry_ms);
            default:    w_hit = 1'b0;
        endcase
    end

    qirt_slot_ram #(.SLOTS(SLOTS)) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_START;
            end
            S_START: begin
                case (r_op)
                    OP_RESERVE: n_state = w_reject ? S_RESP : S_SCAN;
                    OP_ACK:     n_state = (r_id == 16'd0) ? S_RESP : S_SCAN;
                    OP_RETRY:   n_state = S_SCAN;
                    OP_SEND:    n_state = w_tgt_bad ? S_RESP : S_SEND;
                    default:    n_state = S_RESP;
                endcase
            end
            S_SCAN: begin
                if (w_hit || w_last) n_state = S_RESP;
            end
            S_SEND: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || m_axis_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        n_valid   = r_valid;
        n_occ     = r_occ;
        n_pending = r_pending;
        n_idx     = r_idx;
        n_res     = r_res;
        w_rd_en   = 1'b0;
        w_rd_addr = r_idx + 1'b1;
        w_we      = 1'b0;
        w_wr_addr = r_idx;
        w_wr_data = w_rd_data;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;

        case (r_state)
            S_START: begin
                n_res = '{status: ST_OK, slot: 4'd0, id: 16'd0, bytes: 16'd0, dup: 1'b0};
                case (r_op)
                    OP_RESERVE: begin
                        if (w_reject) begin
                            n_res.status = ST_REJECTED;
                        end else begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = '0;
                            n_idx     = '0;
                        end
                    end
                    OP_ACK: begin
                        if (r_id == 16'd0) begin
                            n_res.status = ST_NOT_FOUND;
                        end else begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = '0;
                            n_idx     = '0;
                        end
                    end
                    OP_RETRY: begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = '0;
                        n_idx     = '0;
                    end
                    OP_SEND: begin
                        if (w_tgt_bad) begin
                            n_res.status = ST_NOT_FOUND;
                        end else begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = IW'(r_tgt);
                            n_idx     = IW'(r_tgt);
                        end
                    end
                    OP_CLEAR: begin
                        n_valid   = '0;
                        n_occ     = '0;
                        n_pending = '0;
                    end
                    default: ;
                endcase
            end
            S_SCAN: begin
                // read one entry ahead of the one under test
                w_rd_en = !w_last;
                n_idx   = r_idx + 1'b1;
                if (w_hit) begin
                    n_res.slot = 4'(r_idx);
                    case (r_op)
                        OP_RESERVE: begin
                            w_we      = 1'b1;
                            w_wr_data = '{send_cnt: 8'd0, last_send: r_time,
                                          bytes: r_bytes, id: r_id};
                            n_valid[r_idx] = 1'b1;
                            n_occ     = r_occ + 1'b1;
                            n_pending = w_sum[23:0];
                            n_res.id    = r_id;
                            n_res.bytes = r_bytes;
                        end
                        OP_ACK: begin
                            n_valid[r_idx] = 1'b0;
                            n_occ     = r_occ - 1'b1;
                            n_pending = (r_pending >= {8'd0, w_rd_data.bytes}) ?
                                        r_pending - {8'd0, w_rd_data.bytes} : 24'd0;
                            n_res.id    = w_rd_data.id;
                            n_res.bytes = w_rd_data.bytes;
                        end
                        default: begin
                            // retry check: restamp, then retransmit or exhausted
                            w_we = 1'b1;
                            w_wr_data.last_send = r_time;
                            n_res.id    = w_rd_data.id;
                            n_res.bytes = w_rd_data.bytes;
                            if (w_rd_data.send_cnt >= r_max_send) begin
                                n_res.status = ST_EXHAUSTED;
                            end else begin
                                n_res.status = ST_RETRANSMIT;
                                n_res.dup    = (DUP_BIT != 8'd0);
                            end
                        end
                    endcase
                end else if (w_last) begin
                    case (r_op)
                        OP_RESERVE: n_res.status = ST_FULL;
                        OP_ACK:     n_res.status = ST_NOT_FOUND;
                        default:    n_res.status = ST_NONE_DUE;
                    endcase
                end
            end
            S_SEND: begin
                n_res.slot  = r_tgt;
                n_res.id    = w_rd_data.id;
                n_res.bytes = w_rd_data.bytes;
                if (r_ok && (w_rd_data.send_cnt != 8'hFF)) begin
                    w_we = 1'b1;
                    w_wr_data.send_cnt = w_rd_data.send_cnt + 8'd1;
                end
            end
            S_RESP: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {3'd0, r_pending, 5'(r_occ), r_res.dup, r_res.bytes,
                                   r_res.id, r_res.slot, r_res.status};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_occ       <= '0;
            r_pending   <= '0;
            r_out_valid <= 1'b0;
            r_retry_ms  <= 32'd5000;
            r_max_send  <= 8'd5;
            r_max_bytes <= 24'd65536;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_occ       <= n_occ;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RETRY_MS:  r_retry_ms  <= i_cfg_wdata;
                    CFG_MAX_SEND:  r_max_send  <= i_cfg_wdata[7:0];
                    CFG_MAX_BYTES: r_max_bytes <= i_cfg_wdata[23:0];
                    default: ;
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_res      <= n_res;
        r_out_data <= n_out_data;
        if (w_accept) begin
            r_op    <= s_axis_tdata[2:0];
            r_id    <= s_axis_tdata[18:3];
            r_bytes <= s_axis_tdata[34:19];
            r_time  <= s_axis_tdata[66:35];
            r_tgt   <= s_axis_tdata[70:67];
            r_ok    <= s_axis_tdata[71];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // occupancy counter tracks the valid bits
    `ASSERT_CLK(a_occ_matches, i_clk, i_rst_n, (32'(r_occ) == $countones(r_valid)), "occ count")
    // pending total is the sum of valid slot lengths, so empty means zero
    `ASSERT_CLK(a_empty_zero, i_clk, i_rst_n, (r_occ != '0) || (r_pending == 24'd0), "total")
    // table writes only come from a walk hit or a send result
    `ASSERT_NEVER(a_we_state, i_clk, i_rst_n,
                  w_we && (r_state != S_SCAN) && (r_state != S_SEND), "stray RAM write")
    // a response is loaded only from the response state
    `ASSERT_CLK(a_out_load, i_clk, i_rst_n,
                $rose(r_out_valid) |-> ($past(r_state) == S_RESP), "response outside S_RESP")

endmodule

`default_nettype wire

// File: dv/tb_qos1_inflight_retry_tracker_top.sv
// ---------------------------------------------------------------------------
// QoS1 in-flight retry tracker testbench
// Drives request items into the tracker, mirrors its slot table and byte
// accounting in a local table model, and compares every response in order.
// Directed corner cases run first, then seeded random traffic under several
// register settings, with random valid gaps and ready stalls except in the last.
// ---------------------------------------------------------------------------

module tb_qos1_inflight_retry_tracker_top;
    timeunit 1ns;
    timeprecision 1ps;

    import qirt_pkg::*;

    localparam int NSLOT = SLOTS_DEF;
    // ops 5..7 are undecoded; the block answers them with a plain OK
    localparam logic [2:0] OP_UNDECODED = 3'd5;
    // settle time after the last response, longer than the worst slot walk
    localparam int SETTLE_CYC = NSLOT + 16;

    // request fields, first field in the low bits (matches s_axis_tdata)
    typedef struct packed {
        logic        send_ok;
        logic [3:0]  target_slot;
        logic [31:0] time_ms;
        logic [15:0] msg_bytes;
        logic [15:0] msg_id;
        logic [2:0]  op;
    } t_req;

    // response fields, first field in the low bits (m_axis_tdata[68:0])
    typedef struct packed {
        logic [23:0] total_bytes;
        logic [4:0]  occupied;
        logic        dup;
        logic [15:0] out_bytes;
        logic [15:0] out_id;
        logic [3:0]  slot;
        logic [2:0]  status;
    } t_rsp;

    // ------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------
    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata  = '0;  // op, msg_id, msg_bytes, time_ms,
                                            // target_slot, send_ok
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;        // status, chosen_slot, out_id,
                                            // out_bytes, dup_flag,
                                            // occupied_count, total_bytes
    logic              i_cfg_we      = 1'b0;
    logic [1:0]        i_cfg_idx     = '0;
    logic [CFG_W-1:0]  i_cfg_wdata   = '0;

    qos1_inflight_retry_tracker_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Table model: slot table, byte total and register copies
    // ------------------------------------------------------------------
    logic        tbl_valid [NSLOT];
    logic [15:0] tbl_id    [NSLOT];
    logic [15:0] tbl_bytes [NSLOT];
    logic [31:0] tbl_stamp [NSLOT];
    logic [7:0]  tbl_sends [NSLOT];
    logic [23:0] pend_total = '0;

    logic [31:0] cfg_retry_ms  = 32'd5000;
    logic [7:0]  cfg_max_sends = 8'd5;
    logic [23:0] cfg_max_bytes = 24'd65536;

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_id[i]    = '0;
            tbl_bytes[i] = '0;
            tbl_stamp[i] = '0;
            tbl_sends[i] = '0;
        end
    end

    // free one entry; the byte total floors at zero
    function automatic void free_entry(int i);
        if (tbl_valid[i]) begin
            pend_total   = (pend_total >= tbl_bytes[i]) ? pend_total - tbl_bytes[i] : '0;
            tbl_valid[i] = 1'b0;
        end
    endfunction

    // apply one accepted request to the table model, return the response
    function automatic t_rsp apply_to_table(t_req r);
        t_rsp        rs;
        logic [31:0] sum;
        logic [31:0] age;
        bit          hit;
        int          used;
        rs   = '0;
        hit  = 1'b0;
        used = 0;
        case (r.op)
            OP_RESERVE: begin
                sum = pend_total + r.msg_bytes;
                if (r.msg_id == 16'd0 || sum > cfg_max_bytes) begin
                    rs.status = ST_REJECTED;
                end else begin
                    rs.status = ST_FULL;
                    for (int i = 0; i < NSLOT; i++) begin
                        if (!hit && !tbl_valid[i]) begin
                            hit          = 1'b1;
                            tbl_valid[i] = 1'b1;
                            tbl_id[i]    = r.msg_id;
                            tbl_bytes[i] = r.msg_bytes;
                            tbl_stamp[i] = r.time_ms;
                            tbl_sends[i] = '0;
                            pend_total   = sum[23:0];
                            rs.status    = ST_OK;
                            rs.slot      = 4'(i);
                            rs.out_id    = r.msg_id;
                            rs.out_bytes = r.msg_bytes;
                        end
                    end
                end
            end
            OP_ACK: begin
                rs.status = ST_NOT_FOUND;
                if (r.msg_id != 16'd0) begin
                    for (int i = 0; i < NSLOT; i++) begin
                        if (!hit && tbl_valid[i] && tbl_id[i] == r.msg_id) begin
                            hit          = 1'b1;
                            rs.status    = ST_OK;
                            rs.slot      = 4'(i);
                            rs.out_id    = tbl_id[i];
                            rs.out_bytes = tbl_bytes[i];
                            free_entry(i);
                        end
                    end
                end
            end
            OP_RETRY: begin
                rs.status = ST_NONE_DUE;
                for (int i = 0; i < NSLOT; i++) begin
                    age = r.time_ms - tbl_stamp[i];
                    if (!hit && tbl_valid[i] && age >= cfg_retry_ms) begin
                        hit          = 1'b1;
                        tbl_stamp[i] = r.time_ms;
                        rs.slot      = 4'(i);
                        rs.out_id    = tbl_id[i];
                        rs.out_bytes = tbl_bytes[i];
                        if (tbl_sends[i] >= cfg_max_sends) begin
                            rs.status = ST_EXHAUSTED;
                        end else begin
                            rs.status = ST_RETRANSMIT;
                            rs.dup    = (DUP_BIT != 8'd0);
                        end
                    end
                end
            end
            OP_SEND: begin
                if (!tbl_valid[r.target_slot]) begin
                    rs.status = ST_NOT_FOUND;
                end else begin
                    if (r.send_ok && tbl_sends[r.target_slot] != 8'hFF)
                        tbl_sends[r.target_slot] = tbl_sends[r.target_slot] + 8'd1;
                    rs.status    = ST_OK;
                    rs.slot      = r.target_slot;
                    rs.out_id    = tbl_id[r.target_slot];
                    rs.out_bytes = tbl_bytes[r.target_slot];
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < NSLOT; i++)
                    free_entry(i);
                rs.status = ST_OK;
            end
            default: rs.status = ST_OK;  // undecoded op, no change
        endcase
        for (int i = 0; i < NSLOT; i++)
            if (tbl_valid[i])
                used++;
        rs.occupied    = 5'(used);
        rs.total_bytes = pend_total;
        return rs;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: feeds req_backlog onto s_axis, predicts on acceptance
    // ------------------------------------------------------------------
    t_req req_backlog [$];
    t_rsp due_replies [$];
    t_req on_wire;
    int   gap_left   = 0;
    int   stall_left = 0;
    bit   pace_on    = 1'b1;     // random gaps and stalls enabled
    int   n_queued   = 0;        // requests handed to the driver
    int   n_replied  = 0;        // responses taken from m_axis
    int   n_err      = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                due_replies.push_back(apply_to_table(on_wire));
            // load the next request once the current one is gone
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (req_backlog.size() != 0 &&
                             !(pace_on && $urandom_range(0, 5) == 0)) begin
                    on_wire = req_backlog.pop_front();
                    s_axis_tdata  <= on_wire;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    // idle gap starting with this cycle; gap_left holds the rest of it
                    if (pace_on && req_backlog.size() != 0)
                        gap_left = $urandom_range(0, 4);
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Response monitor: random ready stalls, in-order compare
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rsp got;
        t_rsp want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[68:0];
                n_replied++;
                if (due_replies.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("ERROR: response with none outstanding: st=%0d slot=%0d",
                                 got.status, got.slot);
                end else begin
                    want = due_replies.pop_front();
                    if (got.status !== want.status || got.slot !== want.slot ||
                        got.out_id !== want.out_id || got.out_bytes !== want.out_bytes ||
                        got.dup !== want.dup || got.occupied !== want.occupied ||
                        got.total_bytes !== want.total_bytes) begin
                        n_err++;
                        if (n_err <= 10) begin
                            $display("ERROR: response %0d mismatch", n_replied);
                            $display("  exp st=%0d slot=%0d id=%h bytes=%h dup=%b occ=%0d tot=%h",
                                     want.status, want.slot, want.out_id, want.out_bytes,
                                     want.dup, want.occupied, want.total_bytes);
                            $display("  got st=%0d slot=%0d id=%h bytes=%h dup=%b occ=%0d tot=%h",
                                     got.status, got.slot, got.out_id, got.out_bytes,
                                     got.dup, got.occupied, got.total_bytes);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (pace_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 4);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    logic [31:0] gen_now;        // millisecond clock of the generated traffic
    logic [15:0] live_ids [$];   // ids reserved so far, used to aim acks

    task automatic push_req(logic [2:0] op, logic [15:0] id, logic [15:0] nbytes,
                            logic [31:0] t, logic [3:0] slot, logic ok);
        t_req r;
        r.op          = op;
        r.msg_id      = id;
        r.msg_bytes   = nbytes;
        r.time_ms     = t;
        r.target_slot = slot;
        r.send_ok     = ok;
        req_backlog.push_back(r);
        n_queued++;
    endtask

    // register write; only called while nothing is outstanding
    task automatic set_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_RETRY_MS:  cfg_retry_ms  = val;
            CFG_MAX_SEND:  cfg_max_sends = val[7:0];
            CFG_MAX_BYTES: cfg_max_bytes = val[23:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (n_replied < n_queued)
            @(posedge i_clk);
    endtask

    // packet id: mostly a small pool so acks find their slots
    function automatic logic [15:0] pick_id();
        int k;
        k = $urandom_range(0, 19);
        if (k < 14)
            return 16'($urandom_range(1, 24));
        else if (k < 16 && live_ids.size() != 0)
            return live_ids[$urandom_range(0, live_ids.size() - 1)];
        else if (k < 19)
            return 16'($urandom_range(0, 65535));
        else
            return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    endfunction

    // time moves mostly a little, sometimes by a quarter or one interval, sometimes anywhere
    task automatic advance_clock();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6)
            gen_now = gen_now + $urandom_range(0, 64);
        else if (k < 8)
            gen_now = gen_now + (cfg_retry_ms >> 2) + $urandom_range(0, 3);
        else if (k < 9)
            gen_now = gen_now + cfg_retry_ms;   // all-ones interval steps back by one
        else
            gen_now = gen_now + $urandom();
    endtask

    task automatic queue_random(int count);
        logic [15:0] id;
        logic [15:0] nbytes;
        logic [3:0]  slot;
        logic [2:0]  op;
        int          pick;
        int          j;
        for (int n = 0; n < count; n++) begin
            advance_clock();
            // unused fields carry noise
            id     = 16'($urandom_range(0, 65535));
            nbytes = 16'($urandom_range(0, 65535));
            slot   = 4'($urandom_range(0, NSLOT - 1));
            pick   = $urandom_range(0, 99);
            if (pick < 30) begin
                op = OP_RESERVE;
                id = pick_id();
                j  = $urandom_range(0, 9);
                if (j < 2)      nbytes = 16'd0;
                else if (j < 7) nbytes = 16'($urandom_range(1, 3000));
                else if (j < 8) nbytes = 16'hFFFF;
                live_ids.push_back(id);
            end else if (pick < 48) begin
                op = OP_ACK;
                if (live_ids.size() != 0 && $urandom_range(0, 9) < 6) begin
                    j  = $urandom_range(0, live_ids.size() - 1);
                    id = live_ids[j];
                    live_ids.delete(j);
                end else begin
                    id = pick_id();
                end
            end else if (pick < 66) begin
                op = OP_RETRY;
            end else if (pick < 97) begin
                op = OP_SEND;
                if ($urandom_range(0, 9) < 6)
                    slot = 4'($urandom_range(0, 7));
            end else if (pick < 98) begin
                op = OP_CLEAR;
                live_ids.delete();
            end else begin
                op = 3'(OP_UNDECODED + $urandom_range(0, 2));
            end
            push_req(op, id, nbytes, gen_now, slot, $urandom_range(0, 3) != 0);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        gen_now = $urandom();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed, reset register values ---
        push_req(OP_RESERVE, 16'h0000, 16'd10, 32'd0, 4'd0, 1'b0);     // zero id
        push_req(OP_ACK,     16'h0000, 16'd0,  32'd0, 4'd0, 1'b0);     // zero id ack
        push_req(OP_RETRY,   16'h0000, 16'd0,  32'd0, 4'd0, 1'b0);     // empty table
        push_req(OP_SEND,    16'h0000, 16'd0,  32'd0, 4'd3, 1'b1);     // free slot
        push_req(OP_RESERVE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 4'd0, 1'b1);
        push_req(OP_RESERVE, 16'h0001, 16'd1,  32'd0, 4'd0, 1'b0);     // total hits limit
        push_req(OP_RESERVE, 16'h0002, 16'd1,  32'd0, 4'd0, 1'b0);     // one byte over
        push_req(OP_RESERVE, 16'h0003, 16'd0,  32'd100, 4'hF, 1'b1);   // zero bytes fit
        push_req(OP_SEND,    16'h0000, 16'd0,  32'd0, 4'd0, 1'b1);
        push_req(OP_SEND,    16'h0000, 16'd0,  32'd0, 4'd0, 1'b0);     // deferred send
        push_req(OP_SEND,    16'h0000, 16'd0,  32'd0, 4'hF, 1'b1);
        push_req(OP_RETRY,   16'h0000, 16'd0,  32'd4999, 4'd0, 1'b0);  // due across wrap
        push_req(OP_RETRY,   16'h0000, 16'd0,  32'd4999, 4'd0, 1'b0);  // stamp renewed
        push_req(OP_ACK,     16'h0001, 16'd0,  32'd0, 4'd0, 1'b0);
        push_req(OP_ACK,     16'h0001, 16'd0,  32'd0, 4'd0, 1'b0);     // already freed
        push_req(OP_UNDECODED,         16'h0003, 16'd5, 32'd0, 4'd0, 1'b1);
        push_req(OP_UNDECODED + 3'd2,  16'h0003, 16'd5, 32'd0, 4'd0, 1'b1);
        push_req(OP_CLEAR,   16'h0000, 16'd0,  32'd0, 4'd0, 1'b0);
        drain();

        // --- low extremes: interval 1, budget 1, zero byte limit ---
        set_reg(CFG_RETRY_MS,  32'd1);
        set_reg(CFG_MAX_SEND,  32'd1);
        set_reg(CFG_MAX_BYTES, 32'd0);
        push_req(OP_RESERVE, 16'h0009, 16'd0, 32'd100, 4'd0, 1'b0);
        push_req(OP_RESERVE, 16'h000A, 16'd1, 32'd100, 4'd0, 1'b0);    // over zero limit
        push_req(OP_SEND,    16'h0000, 16'd0, 32'd0, 4'd0, 1'b1);
        push_req(OP_RETRY,   16'h0000, 16'd0, 32'd101, 4'd0, 1'b0);    // budget exhausted
        push_req(OP_RETRY,   16'h0000, 16'd0, 32'd101, 4'd0, 1'b0);
        push_req(OP_ACK,     16'h0009, 16'd0, 32'd0, 4'd0, 1'b0);
        push_req(OP_CLEAR,   16'h0000, 16'd0, 32'd0, 4'd0, 1'b0);
        queue_random(150);
        drain();

        // --- send count saturation: 256 completed sends on one slot ---
        set_reg(CFG_MAX_SEND,  32'd255);
        set_reg(CFG_MAX_BYTES, 32'h00FF_FFFF);
        push_req(OP_CLEAR,   16'h0000, 16'd0, 32'd0, 4'd0, 1'b0);
        push_req(OP_RESERVE, 16'h5A5A, 16'h1234, 32'd1000, 4'd0, 1'b0);
        for (int i = 0; i < 254; i++)
            push_req(OP_SEND, 16'h0000, 16'd0, 32'd0, 4'd0, 1'b1);
        push_req(OP_RETRY, 16'h0000, 16'd0, 32'd1001, 4'd0, 1'b0);     // 254 sent
        push_req(OP_SEND,  16'h0000, 16'd0, 32'd0, 4'd0, 1'b1);
        push_req(OP_SEND,  16'h0000, 16'd0, 32'd0, 4'd0, 1'b1);        // stays at 255
        push_req(OP_RETRY, 16'h0000, 16'd0, 32'd1002, 4'd0, 1'b0);
        push_req(OP_CLEAR, 16'h0000, 16'd0, 32'd0, 4'd0, 1'b0);
        drain();

        // --- high extremes: all-ones interval, full budget and byte limit ---
        set_reg(CFG_RETRY_MS, 32'hFFFF_FFFF);
        live_ids.delete();
        queue_random(200);
        drain();

        // --- reset-like values ---
        set_reg(CFG_RETRY_MS,  32'd5000);
        set_reg(CFG_MAX_SEND,  32'd5);
        set_reg(CFG_MAX_BYTES, 32'd65536);
        queue_random(250);
        drain();

        // --- random mid-range settings, full throughput to the end ---
        set_reg(CFG_RETRY_MS,  $urandom_range(1, 3000));
        set_reg(CFG_MAX_SEND,  $urandom_range(1, 4));
        set_reg(CFG_MAX_BYTES, $urandom_range(1000, 100000));
        pace_on = 1'b0;
        queue_random(250);
        drain();

        repeat (SETTLE_CYC) @(posedge i_clk);
        if (n_err == 0 && due_replies.size() == 0 && n_replied == n_queued)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

endmodule
